>>> rtl/core/sc2a_pkg.sv
package sc2a_pkg;

   // Set-1 modifier and release codes
   localparam logic [7:0] LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] CAPS_MAKE    = 8'h3A;
   localparam int unsigned BREAK_BIT   = 7;

   // Word kinds
   localparam logic KIND_SCAN = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic       shift_flag;
      logic       caps_flag;
      logic [6:0] held_char;
      logic       held_ready;
   } key_state_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       char_valid;
      logic [6:0] key_code;
      logic       shift_active;
      logic       caps_active;
   } result_type;

   function automatic logic [6:0] plain_char(input logic [6:0] idx);
      logic [6:0] c;
      case (idx)
         7'd1:    c = 7'h1B;
         7'd2:    c = 7'h31;
         7'd3:    c = 7'h32;
         7'd4:    c = 7'h33;
         7'd5:    c = 7'h34;
         7'd6:    c = 7'h35;
         7'd7:    c = 7'h36;
         7'd8:    c = 7'h37;
         7'd9:    c = 7'h38;
         7'd10:   c = 7'h39;
         7'd11:   c = 7'h30;
         7'd12:   c = 7'h2D;
         7'd13:   c = 7'h3D;
         7'd14:   c = 7'h08;
         7'd15:   c = 7'h09;
         7'd16:   c = 7'h71;
         7'd17:   c = 7'h77;
         7'd18:   c = 7'h65;
         7'd19:   c = 7'h72;
         7'd20:   c = 7'h74;
         7'd21:   c = 7'h79;
         7'd22:   c = 7'h75;
         7'd23:   c = 7'h69;
         7'd24:   c = 7'h6F;
         7'd25:   c = 7'h70;
         7'd26:   c = 7'h5B;
         7'd27:   c = 7'h5D;
         7'd28:   c = 7'h0A;
         7'd30:   c = 7'h61;
         7'd31:   c = 7'h73;
         7'd32:   c = 7'h64;
         7'd33:   c = 7'h66;
         7'd34:   c = 7'h67;
         7'd35:   c = 7'h68;
         7'd36:   c = 7'h6A;
         7'd37:   c = 7'h6B;
         7'd38:   c = 7'h6C;
         7'd39:   c = 7'h3B;
         7'd40:   c = 7'h27;
         7'd41:   c = 7'h60;
         7'd43:   c = 7'h5C;
         7'd44:   c = 7'h7A;
         7'd45:   c = 7'h78;
         7'd46:   c = 7'h63;
         7'd47:   c = 7'h76;
         7'd48:   c = 7'h62;
         7'd49:   c = 7'h6E;
         7'd50:   c = 7'h6D;
         7'd51:   c = 7'h2C;
         7'd52:   c = 7'h2E;
         7'd53:   c = 7'h2F;
         7'd55:   c = 7'h2A;
         7'd57:   c = 7'h20;
         7'd74:   c = 7'h2D;
         7'd78:   c = 7'h2B;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] shifted_char(input logic [6:0] idx);
      logic [6:0] c;
      case (idx)
         7'd1:    c = 7'h1B;
         7'd2:    c = 7'h21;
         7'd3:    c = 7'h40;
         7'd4:    c = 7'h23;
         7'd5:    c = 7'h24;
         7'd6:    c = 7'h25;
         7'd7:    c = 7'h5E;
         7'd8:    c = 7'h26;
         7'd9:    c = 7'h2A;
         7'd10:   c = 7'h28;
         7'd11:   c = 7'h29;
         7'd12:   c = 7'h5F;
         7'd13:   c = 7'h2B;
         7'd14:   c = 7'h08;
         7'd15:   c = 7'h09;
         7'd16:   c = 7'h51;
         7'd17:   c = 7'h57;
         7'd18:   c = 7'h45;
         7'd19:   c = 7'h52;
         7'd20:   c = 7'h54;
         7'd21:   c = 7'h59;
         7'd22:   c = 7'h55;
         7'd23:   c = 7'h49;
         7'd24:   c = 7'h4F;
         7'd25:   c = 7'h50;
         7'd26:   c = 7'h7B;
         7'd27:   c = 7'h7D;
         7'd28:   c = 7'h0A;
         7'd30:   c = 7'h41;
         7'd31:   c = 7'h53;
         7'd32:   c = 7'h44;
         7'd33:   c = 7'h46;
         7'd34:   c = 7'h47;
         7'd35:   c = 7'h48;
         7'd36:   c = 7'h4A;
         7'd37:   c = 7'h4B;
         7'd38:   c = 7'h4C;
         7'd39:   c = 7'h3A;
         7'd40:   c = 7'h22;
         7'd41:   c = 7'h7E;
         7'd43:   c = 7'h7C;
         7'd44:   c = 7'h5A;
         7'd45:   c = 7'h58;
         7'd46:   c = 7'h43;
         7'd47:   c = 7'h56;
         7'd48:   c = 7'h42;
         7'd49:   c = 7'h4E;
         7'd50:   c = 7'h4D;
         7'd51:   c = 7'h3C;
         7'd52:   c = 7'h3E;
         7'd53:   c = 7'h3F;
         7'd55:   c = 7'h2A;
         7'd57:   c = 7'h20;
         7'd74:   c = 7'h2D;
         7'd78:   c = 7'h2B;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/sc2a_in_stage.sv
module sc2a_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_scan_byte,
   input  logic       drain,
   output logic       held_valid,
   output logic       held_kind,
   output logic [7:0] held_scan_byte
);

   logic       valid_ff, valid_in;
   logic       kind_ff;
   logic [7:0] byte_ff;
   logic       take;

   // Free when empty or when the held word moves on this cycle
   assign req_ready = !valid_ff || drain;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         kind_ff <= req_kind;
         byte_ff <= req_scan_byte;
      end
   end

   assign held_valid     = valid_ff;
   assign held_kind      = kind_ff;
   assign held_scan_byte = byte_ff;

endmodule

>>> rtl/core/sc2a_decode.sv
module sc2a_decode (
   input  logic                   kind,
   input  logic [7:0]             scan_byte,
   input  sc2a_pkg::key_state_type state_cur,
   output sc2a_pkg::key_state_type state_nxt,
   output sc2a_pkg::result_type    result
);

   logic [6:0] idx;
   logic [6:0] looked_up;

   assign idx       = scan_byte[6:0];
   assign looked_up = (state_cur.shift_flag ^ state_cur.caps_flag)
                      ? sc2a_pkg::shifted_char(idx) : sc2a_pkg::plain_char(idx);

   always_comb begin
      state_nxt         = state_cur;
      result.ascii_char = 7'h00;
      result.char_valid = 1'b0;
      result.key_code   = 7'h00;
      if (kind == sc2a_pkg::KIND_READ) begin
         if (state_cur.held_ready) begin
            result.ascii_char    = state_cur.held_char;
            result.char_valid    = 1'b1;
            state_nxt.held_ready = 1'b0;
         end
      end else if (scan_byte inside {sc2a_pkg::LSHIFT_MAKE, sc2a_pkg::RSHIFT_MAKE}) begin
         state_nxt.shift_flag = 1'b1;
      end else if (scan_byte inside {sc2a_pkg::LSHIFT_BREAK, sc2a_pkg::RSHIFT_BREAK}) begin
         state_nxt.shift_flag = 1'b0;
      end else if (scan_byte == sc2a_pkg::CAPS_MAKE) begin
         state_nxt.caps_flag = !state_cur.caps_flag;
      end else if (!scan_byte[sc2a_pkg::BREAK_BIT] && looked_up != 7'h00) begin
         // latch the key; releases and unmapped codes leave everything alone
         state_nxt.held_char  = looked_up;
         state_nxt.held_ready = 1'b1;
         result.ascii_char    = looked_up;
         result.char_valid    = 1'b1;
         result.key_code      = idx;
      end
      result.shift_active = state_nxt.shift_flag;
      result.caps_active  = state_nxt.caps_flag;
   end

endmodule

>>> rtl/core/scancode_to_ascii_decoder_core.sv
// Channel   Direction  Ports                                   Word
// req_      in         req_valid/req_ready                     kind, scan_byte
// rsp_      out        rsp_valid/rsp_ready                     ascii_char, char_valid,
//                                                              key_code, shift_active,
//                                                              caps_active
//
// One word enters per cycle while req_ready is high. Its result is registered
// in order (input register, then table lookup and flag update into the result
// register) and holds there until rsp_ready takes it. Sustained rate is one
// word per cycle while rsp_ready stays high, set by the single lookup stage.
// Synchronous active-high reset clears the flags, the held key and both valids.
// A stalled result holds in its register while the input register still takes
// one more word; req_ready drops only when both registers are full and stalled.
module scancode_to_ascii_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_ascii_char,
   output logic       rsp_char_valid,
   output logic [6:0] rsp_key_code,
   output logic       rsp_shift_active,
   output logic       rsp_caps_active
);

   logic       in_valid;
   logic       in_kind;
   logic [7:0] in_scan_byte;
   logic       advance;

   sc2a_pkg::key_state_type state_ff, state_in;
   sc2a_pkg::result_type    result_in, result_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Move the held word into the result register when that register frees up
   assign advance = in_valid && (!rsp_valid_ff || rsp_ready);

   sc2a_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_scan_byte  (req_scan_byte),
      .drain          (advance),
      .held_valid     (in_valid),
      .held_kind      (in_kind),
      .held_scan_byte (in_scan_byte)
   );

   sc2a_decode u_decode (
      .kind      (in_kind),
      .scan_byte (in_scan_byte),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         // commit the flags only when the word is actually consumed
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ascii_char   = result_ff.ascii_char;
   assign rsp_char_valid   = result_ff.char_valid;
   assign rsp_key_code     = result_ff.key_code;
   assign rsp_shift_active = result_ff.shift_active;
   assign rsp_caps_active  = result_ff.caps_active;

`ifndef NO_ASSERTIONS
   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_char_valid |-> rsp_ascii_char != 7'h00)
      else $error("valid character word carries a zero character");

   a_code_implies_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_key_code != 7'h00 |-> rsp_char_valid)
      else $error("key code reported without a character");

   a_flags_match_state: assert property (@(posedge clock) disable iff (reset)
      advance && !reset |=> rsp_shift_active == state_ff.shift_flag
                            && rsp_caps_active == state_ff.caps_flag)
      else $error("result flags differ from committed state");

   a_ready_only_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid && rsp_valid_ff && !rsp_ready)
      else $error("input stalled while a stage was free");
`endif

endmodule
